// ----- rtl/bpc_pkg.sv -----
// Shared types, constants and helpers for the barometric compensation unit.
// No dependencies; used by every module in rtl/.
package bpc_pkg;

  localparam int CalcWidth = 64;
  localparam int CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_TEMP_CAL = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PRESS_A  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_PRESS_B  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_PRESS_C  = 2'd3;

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] PressBase  = 64'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam logic [63:0] P1Bias     = 64'd1 << 47;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_DONE
  } bpc_state_t;

  typedef enum logic [3:0] {
    ST_T1, ST_T2, ST_T3,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
    ST_P7, ST_P8, ST_P9, ST_P10, ST_P11, ST_PFIN
  } bpc_step_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ----- rtl/bpc_mul.sv -----
// Bit-serial shift-add multiplier, product modulo 2^W, one multiplier bit per cycle.
// Depends on bpc_pkg.
module bpc_mul import bpc_pkg::*; #(
  parameter int W = CalcWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CntW = $clog2(W);
  localparam logic [CntW-1:0] LastCnt = CntW'(W - 1);

  logic [W-1:0]    acc;
  logic [W-1:0]    ma;
  logic [W-1:0]    mb;
  logic [CntW-1:0] cnt;
  logic            busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == LastCnt);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LastCnt) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ma  <= a;
      mb  <= b;
      cnt <= '0;
    end else if (busy) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma  <= {ma[W-2:0], 1'b0};
      mb  <= {1'b0, mb[W-1:1]};
      cnt <= cnt + 1'b1;
    end
  end

  assign prod = acc;

endmodule

// ----- rtl/bpc_div.sv -----
// Restoring signed divider, truncates toward zero, one quotient bit per cycle.
// Depends on bpc_pkg. Divisor must be nonzero.
module bpc_div import bpc_pkg::*; #(
  parameter int W = CalcWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CntW = $clog2(W);
  localparam logic [CntW-1:0] LastCnt = CntW'(W - 1);

  logic [W-1:0]    rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    mag_b;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            fix;
  logic            neg;
  logic [W:0]      trial;
  logic [W:0]      diff;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix && !start;
      fix  <= busy && !start && (cnt == LastCnt);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LastCnt) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      mag_b <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
      neg   <= dividend[W-1] ^ divisor[W-1];
      cnt   <= '0;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= trial[W-1:0];
      end
      quo <= {quo[W-2:0], ~diff[W]};
      cnt <= cnt + 1'b1;
    end else if (fix && neg) begin
      quo <= ~quo + 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/baro_temp_pressure_compensation_unit.sv -----
// Barometric temperature / pressure compensation, integer fixed-point scheme.
// Sequencer over a shared serial multiplier (bpc_mul) and divider (bpc_div);
// depends on bpc_pkg.
//
// Usage:
//  - Input request (in_valid/in_ready): operation, raw_temperature,
//    raw_pressure. in_ready is high only while the sequencer is idle.
//  - Output request (out_valid/out_ready): temperature_centi,
//    pressure_q24_8, divide_guard, held in an output register.
//  - Calibration: cfg_write/cfg_index/cfg_data, written while idle.
//  - Every multiply and the divide are bit-serial. A temperature request
//    takes three multiplies. A pressure request also recomputes the fine
//    temperature first when none is held (fine is zero); with a zero
//    divisor it stops before the divide.
//  - The serial multiplier bounds throughput: one request at a time.
//  - A new request is taken while the previous result waits in the output
//    register; the next result waits in the sequencer until it drains.
//  - Synchronous reset clears calibration, the fine temperature and the
//    state, valid and busy flags (not the step register); no clearing pass.
module baro_temp_pressure_compensation_unit import bpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [19:0]            raw_temperature,
  input  logic [19:0]            raw_pressure,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     temperature_centi,
  output logic [31:0]            pressure_q24_8,
  output logic                   divide_guard,
  input  logic                   cfg_write,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  logic [47:0] temp_cal;
  logic [63:0] press_a;
  logic [63:0] press_b;
  logic [15:0] press_c;

  bpc_state_t state, state_next;
  bpc_step_t  step;

  logic        op;
  logic [19:0] rt;
  logic [19:0] rp;
  logic [31:0] fine;
  logic [31:0] ta;
  logic [31:0] tb;
  logic [63:0] v1;
  logic [63:0] v2;
  logic [63:0] m4;
  logic [63:0] pr;
  logic [31:0] press;
  logic        guard;

  logic        mul_start, div_start;
  logic [63:0] mul_a, mul_b;
  logic        mul_done, div_done;
  logic [63:0] prod, quo;
  logic        unit_done;
  logic        finish;

  logic [63:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] d1, d2;
  logic [63:0] v1_init;
  logic [63:0] p_shift;
  logic [63:0] pr_sc;
  logic [63:0] v1_scaled;
  logic [31:0] tc_sum;
  logic        accept;
  logic        room;

  assign t1 = {48'd0, temp_cal[15:0]};
  assign t2 = sx16(temp_cal[31:16]);
  assign t3 = sx16(temp_cal[47:32]);
  assign p1 = {48'd0, press_a[15:0]};
  assign p2 = sx16(press_a[31:16]);
  assign p3 = sx16(press_a[47:32]);
  assign p4 = sx16(press_a[63:48]);
  assign p5 = sx16(press_b[15:0]);
  assign p6 = sx16(press_b[31:16]);
  assign p7 = sx16(press_b[47:32]);
  assign p8 = sx16(press_b[63:48]);
  assign p9 = sx16(press_c);

  assign d1      = {15'd0, rt[19:3]} - {15'd0, temp_cal[15:0], 1'b0};
  assign d2      = {16'd0, rt[19:4]} - {16'd0, temp_cal[15:0]};
  assign v1_init = sx32(fine) - FineOffset;
  assign p_shift = (PressBase - {44'd0, rp}) << 31;
  assign pr_sc   = 64'($signed(pr) >>> 13);
  assign v1_scaled = 64'($signed(prod) >>> 33);
  assign tc_sum  = {fine[29:0], 2'b00} + fine + 32'd128;

  assign accept    = in_valid && in_ready;
  assign room      = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign unit_done = mul_done || div_done;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0;
      press_a  <= '0;
      press_b  <= '0;
      press_c  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEMP_CAL: temp_cal <= cfg_data[47:0];
        CFG_PRESS_A:  press_a  <= cfg_data;
        CFG_PRESS_B:  press_b  <= cfg_data;
        CFG_PRESS_C:  press_c  <= cfg_data[15:0];
        default:      ;
      endcase
    end
  end

  // operand selection for the current step
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    if (state == S_RUN) begin
      mul_start = 1'b1;
      case (step)
        ST_T1:   begin mul_a = sx32(d1); mul_b = t2; end
        ST_T2:   begin mul_a = sx32(d2); mul_b = sx32(d2); end
        ST_T3:   begin mul_a = sx32(tb); mul_b = t3; end
        ST_P1:   begin mul_a = v1_init; mul_b = v1_init; end
        ST_P2:   begin mul_a = m4; mul_b = p6; end
        ST_P3:   begin mul_a = v1; mul_b = p5; end
        ST_P4:   begin mul_a = m4; mul_b = p3; end
        ST_P5:   begin mul_a = v1; mul_b = p2; end
        ST_P6:   begin mul_a = P1Bias + v1; mul_b = p1; end
        ST_P7:   begin mul_a = p_shift - v2; mul_b = PressScale; end
        ST_P8:   begin mul_start = 1'b0; div_start = 1'b1; end
        ST_P9:   begin mul_a = p9; mul_b = pr_sc; end
        ST_P10:  begin mul_a = m4; mul_b = pr_sc; end
        ST_P11:  begin mul_a = p8; mul_b = pr; end
        ST_PFIN: mul_start = 1'b0;
        default: mul_start = 1'b0;
      endcase
    end
  end

  // request ends on a unit result: temperature done, or zero divisor (pressure ends at ST_PFIN)
  always_comb begin
    case (step)
      ST_T3:   finish = !op;
      ST_P6:   finish = (v1_scaled == '0);
      default: finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RUN;
      S_RUN:  state_next = (step == ST_PFIN) ? S_DONE : S_WAIT;
      S_WAIT: if (unit_done) state_next = finish ? S_DONE : S_RUN;
      S_DONE: if (room) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // fine temperature is state
  always_ff @(posedge clk) begin
    if (rst) begin
      fine <= '0;
    end else if (state == S_WAIT && unit_done && step == ST_T3) begin
      fine <= ta + 32'($signed(prod[31:0]) >>> 14);
    end
  end

  // datapath writeback and step sequencing
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= operation;
      rt    <= raw_temperature;
      rp    <= raw_pressure;
      press <= '0;
      guard <= 1'b0;
      step  <= (!operation || fine == '0) ? ST_T1 : ST_P1;
    end else if (state == S_RUN) begin
      if (step == ST_P1) begin
        v1 <= v1_init;
      end
      if (step == ST_PFIN) begin
        press <= 32'(64'($signed(pr + v2) >>> 8) + (p7 << 4));
      end
    end else if (state == S_WAIT && unit_done) begin
      case (step)
        ST_T1:  begin ta <= 32'($signed(prod[31:0]) >>> 11); step <= ST_T2; end
        ST_T2:  begin tb <= 32'($signed(prod[31:0]) >>> 12); step <= ST_T3; end
        ST_T3:  step <= ST_P1;
        ST_P1:  begin m4 <= prod; step <= ST_P2; end
        ST_P2:  begin v2 <= prod; step <= ST_P3; end
        ST_P3:  begin v2 <= v2 + (prod << 17) + (p4 << 35); step <= ST_P4; end
        ST_P4:  begin m4 <= 64'($signed(prod) >>> 8); step <= ST_P5; end
        ST_P5:  begin v1 <= m4 + (prod << 12); step <= ST_P6; end
        ST_P6: begin
          v1 <= v1_scaled;
          if (v1_scaled == '0) begin
            guard <= 1'b1;
          end
          step <= ST_P7;
        end
        ST_P7:  begin m4 <= prod; step <= ST_P8; end
        ST_P8:  begin pr <= quo; step <= ST_P9; end
        ST_P9:  begin m4 <= prod; step <= ST_P10; end
        ST_P10: begin v1 <= 64'($signed(prod) >>> 25); step <= ST_P11; end
        ST_P11: begin v2 <= 64'($signed(prod) >>> 19) + v1; step <= ST_PFIN; end
        default: step <= ST_PFIN;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && room) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && room) begin
      temperature_centi <= $signed(tc_sum) >>> 8;
      pressure_q24_8    <= press;
      divide_guard      <= guard;
    end
  end

  bpc_mul #(.W(CalcWidth)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  bpc_div #(.W(CalcWidth)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (m4),
    .divisor  (v1),
    .done     (div_done),
    .quotient (quo)
  );

endmodule

// ----- rtl/bpc_checker.sv -----
// Port-level checks for the compensation unit, bound to the top level.
// Depends on bpc_pkg and baro_temp_pressure_compensation_unit.
module bpc_checker import bpc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pressure_q24_8,
  input logic        divide_guard
);

  logic last_op;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      last_op <= operation;
    end
  end

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_q24_8) && $stable(divide_guard))
    else $error("result changed while stalled");

  // one request in flight: no back-to-back accept
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_guard_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_guard |-> pressure_q24_8 == '0)
    else $error("guarded result not zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_temp_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && in_ready && !last_op |-> pressure_q24_8 == '0 && !divide_guard)
    else $error("temperature request gave pressure output");

endmodule

bind baro_temp_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .operation      (operation),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pressure_q24_8 (pressure_q24_8),
  .divide_guard   (divide_guard)
);
